FILE: rtl/assert_macros.svh
// Assertion macros included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion that is off during reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that is checked in reset too.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`endif

FILE: rtl/cam_pkg.sv
// Package for the Camellia cipher: types, constants, S-box and round functions.
package cam_pkg;
	localparam int NumRounds = 24;
	localparam int NumCells = NumRounds + 4;
	localparam int CfgIdxW = 3;

	typedef enum logic [CfgIdxW-1:0] {
		REG_KEY_SIZE = 3'd0,
		REG_KEY_W0 = 3'd1,
		REG_KEY_W1 = 3'd2,
		REG_KEY_W2 = 3'd3,
		REG_KEY_W3 = 3'd4
	} cfg_reg_t;

	localparam logic [63:0] SIG0 = 64'ha09e667f3bcc908b;
	localparam logic [63:0] SIG1 = 64'hb67ae8584caa73b2;
	localparam logic [63:0] SIG2 = 64'hc6ef372fe94f82be;
	localparam logic [63:0] SIG3 = 64'h54ff53a5f1d36f1c;
	localparam logic [63:0] SIG4 = 64'h10e527fade682d1d;
	localparam logic [63:0] SIG5 = 64'hb05688c2b3e6c1fd;

	// Cell operation codes
	typedef enum logic [1:0] {
		OP_PASS = 2'd0,
		OP_F = 2'd1,
		OP_FL = 2'd2
	} cell_op_t;

	// One beat traveling along the chain
	typedef struct packed {
		logic        vld;
		logic        dec;
		logic [63:0] a;
		logic [63:0] b;
	} blk_t;

	// All subkeys
	typedef struct packed {
		logic [3:0][63:0]  kw;
		logic [5:0][63:0]  ke;
		logic [23:0][63:0] k;
	} subkeys_t;

	localparam logic [7:0] SBOX1 [256] = '{
		8'd112,8'd130,8'd44,8'd236,8'd179,8'd39,8'd192,8'd229,
		8'd228,8'd133,8'd87,8'd53,8'd234,8'd12,8'd174,8'd65,
		8'd35,8'd239,8'd107,8'd147,8'd69,8'd25,8'd165,8'd33,
		8'd237,8'd14,8'd79,8'd78,8'd29,8'd101,8'd146,8'd189,
		8'd134,8'd184,8'd175,8'd143,8'd124,8'd235,8'd31,8'd206,
		8'd62,8'd48,8'd220,8'd95,8'd94,8'd197,8'd11,8'd26,
		8'd166,8'd225,8'd57,8'd202,8'd213,8'd71,8'd93,8'd61,
		8'd217,8'd1,8'd90,8'd214,8'd81,8'd86,8'd108,8'd77,
		8'd139,8'd13,8'd154,8'd102,8'd251,8'd204,8'd176,8'd45,
		8'd116,8'd18,8'd43,8'd32,8'd240,8'd177,8'd132,8'd153,
		8'd223,8'd76,8'd203,8'd194,8'd52,8'd126,8'd118,8'd5,
		8'd109,8'd183,8'd169,8'd49,8'd209,8'd23,8'd4,8'd215,
		8'd20,8'd88,8'd58,8'd97,8'd222,8'd27,8'd17,8'd28,
		8'd50,8'd15,8'd156,8'd22,8'd83,8'd24,8'd242,8'd34,
		8'd254,8'd68,8'd207,8'd178,8'd195,8'd181,8'd122,8'd145,
		8'd36,8'd8,8'd232,8'd168,8'd96,8'd252,8'd105,8'd80,
		8'd170,8'd208,8'd160,8'd125,8'd161,8'd137,8'd98,8'd151,
		8'd84,8'd91,8'd30,8'd149,8'd224,8'd255,8'd100,8'd210,
		8'd16,8'd196,8'd0,8'd72,8'd163,8'd247,8'd117,8'd219,
		8'd138,8'd3,8'd230,8'd218,8'd9,8'd63,8'd221,8'd148,
		8'd135,8'd92,8'd131,8'd2,8'd205,8'd74,8'd144,8'd51,
		8'd115,8'd103,8'd246,8'd243,8'd157,8'd127,8'd191,8'd226,
		8'd82,8'd155,8'd216,8'd38,8'd200,8'd55,8'd198,8'd59,
		8'd129,8'd150,8'd111,8'd75,8'd19,8'd190,8'd99,8'd46,
		8'd233,8'd121,8'd167,8'd140,8'd159,8'd110,8'd188,8'd142,
		8'd41,8'd245,8'd249,8'd182,8'd47,8'd253,8'd180,8'd89,
		8'd120,8'd152,8'd6,8'd106,8'd231,8'd70,8'd113,8'd186,
		8'd212,8'd37,8'd171,8'd66,8'd136,8'd162,8'd141,8'd250,
		8'd114,8'd7,8'd185,8'd85,8'd248,8'd238,8'd172,8'd10,
		8'd54,8'd73,8'd42,8'd104,8'd60,8'd56,8'd241,8'd164,
		8'd64,8'd40,8'd211,8'd123,8'd187,8'd201,8'd67,8'd193,
		8'd21,8'd227,8'd173,8'd244,8'd119,8'd199,8'd128,8'd158
	};

	function automatic logic [7:0] rot8(input logic [7:0] v, input int n);
		logic [15:0] w;
		w = {v, v} << n;
		return w[15:8];
	endfunction

	// S-function followed by P-function
	function automatic logic [63:0] camf(input logic [63:0] x);
		logic [7:0] t1, t2, t3, t4, t5, t6, t7, t8;
		logic [7:0] y1, y2, y3, y4, y5, y6, y7, y8;
		t1 = SBOX1[x[63:56]];
		t2 = rot8(SBOX1[x[55:48]], 1);
		t3 = rot8(SBOX1[x[47:40]], 7);
		t4 = SBOX1[rot8(x[39:32], 1)];
		t5 = rot8(SBOX1[x[31:24]], 1);
		t6 = rot8(SBOX1[x[23:16]], 7);
		t7 = SBOX1[rot8(x[15:8], 1)];
		t8 = SBOX1[x[7:0]];
		y1 = t1 ^ t3 ^ t4 ^ t6 ^ t7 ^ t8;
		y2 = t1 ^ t2 ^ t4 ^ t5 ^ t7 ^ t8;
		y3 = t1 ^ t2 ^ t3 ^ t5 ^ t6 ^ t8;
		y4 = t2 ^ t3 ^ t4 ^ t5 ^ t6 ^ t7;
		y5 = t1 ^ t2 ^ t6 ^ t7 ^ t8;
		y6 = t2 ^ t3 ^ t5 ^ t7 ^ t8;
		y7 = t3 ^ t4 ^ t5 ^ t6 ^ t8;
		y8 = t1 ^ t4 ^ t5 ^ t6 ^ t7;
		return {y1, y2, y3, y4, y5, y6, y7, y8};
	endfunction

	function automatic logic [63:0] layer_fl(input logic [63:0] x, input logic [63:0] k);
		logic [31:0] a, b, t;
		a = x[63:32];
		b = x[31:0];
		t = a & k[63:32];
		b = b ^ {t[30:0], t[31]};
		a = a ^ (b | k[31:0]);
		return {a, b};
	endfunction

	function automatic logic [63:0] layer_flinv(input logic [63:0] x, input logic [63:0] k);
		logic [31:0] a, b, t;
		a = x[63:32];
		b = x[31:0];
		a = a ^ (b | k[31:0]);
		t = a & k[63:32];
		b = b ^ {t[30:0], t[31]};
		return {a, b};
	endfunction

	function automatic logic [127:0] rot128(input logic [127:0] v, input int n);
		logic [255:0] w;
		w = {v, v} << n;
		return w[255:128];
	endfunction
endpackage

FILE: rtl/cam_if.sv
// Valid/ready channel interfaces for blocks and configuration writes.
interface cam_blk_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [63:0] data_high;
	logic [63:0] data_low;
	modport source (output valid, kind, data_high, data_low, input ready);
	modport sink (input valid, kind, data_high, data_low, output ready);
endinterface

interface cam_res_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_high;
	logic [63:0] result_low;
	modport source (output valid, result_high, result_low, input ready);
	modport sink (input valid, result_high, result_low, output ready);
endinterface

interface cam_cfg_if;
	logic        valid;
	logic        ready;
	logic [cam_pkg::CfgIdxW-1:0] index;
	logic [63:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/camellia_block_cipher.sv
// Top level of the Camellia cipher: config registers, key schedule, cell chain.
// Usage:
//   blk_in  : one 128-bit block per beat, kind selects encrypt (0) or decrypt (1).
//   res_out : the transformed block, one beat per input beat, in order.
//   cfg     : register writes (key size, four key words); write only while idle
//             and allow about eight cycles before the next block.
// Throughput: one block per cycle unless the output stalls. The chain has 24
//   round cells, three FL cells and the input whitening cell (28 registers).
// 128-bit keys pass through the last six round cells and one FL cell unchanged.
// The whole chain advances as one: when res_out is stalled with a result
//   waiting, blk_in.ready drops and every cell holds its beat.
// Reset clears all valid bits and the configuration registers to zero
//   (128-bit key of all zeros).
module camellia_block_cipher (
	input  logic clk,
	input  logic arst_n,
	cam_blk_if.sink   blk_in,
	cam_res_if.source res_out,
	cam_cfg_if.sink   cfg
);
	localparam int NR = cam_pkg::NumRounds;
	logic [1:0]  key_size_mode_q;
	logic [63:0] kw0_q, kw1_q, kw2_q, kw3_q;
	logic        long_key;
	cam_pkg::subkeys_t sk;
	logic        adv;

	// Configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_size_mode_q <= 2'd0;
			kw0_q <= '0; kw1_q <= '0; kw2_q <= '0; kw3_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				cam_pkg::REG_KEY_SIZE: key_size_mode_q <= cfg.data[1:0];
				cam_pkg::REG_KEY_W0: kw0_q <= cfg.data;
				cam_pkg::REG_KEY_W1: kw1_q <= cfg.data;
				cam_pkg::REG_KEY_W2: kw2_q <= cfg.data;
				cam_pkg::REG_KEY_W3: kw3_q <= cfg.data;
				default: ;
			endcase
		end
	end

	cam_keysched u_ks (
		.clk, .key_size_mode(key_size_mode_q),
		.kw0(kw0_q), .kw1(kw1_q), .kw2(kw2_q), .kw3(kw3_q),
		.long_key, .sk
	);

	// Chain: cell 0 input whitening, 1..24 rounds with FL cells after 6 and 12
	// and 18, last cell output whitening (handled combinationally at the end).
	// Layout: in-white, R1..R6, FL, R7..R12, FL, R13..R18, FL, R19..R24 = 28 cells.
	localparam int NC = cam_pkg::NumCells;
	cam_pkg::blk_t chain [NC+1];
	cam_pkg::blk_t in_blk;

	assign adv = !chain[NC].vld || res_out.ready;
	assign blk_in.ready = adv;
	assign in_blk.vld = blk_in.valid;
	assign in_blk.dec = blk_in.kind;
	assign in_blk.a = blk_in.data_high;
	assign in_blk.b = blk_in.data_low;
	assign chain[0] = in_blk;

	for (genvar c = 0; c < NC; c++) begin : g_cell
		localparam int Grp = (c == 0) ? 0 : (c - 1) / 7;
		localparam int Rnd = (c == 0) ? 0 : (c - 1) % 7;
		cam_pkg::cell_op_t op;
		logic [63:0] ka, kb;
		always_comb begin
			int idx, gg;
			op = cam_pkg::OP_PASS;
			ka = '0;
			kb = '0;
			idx = 6*Grp + Rnd;
			gg = 0;
			if (c == 0) begin
				// whitening: xor as F-less pass with key on both halves
				op = cam_pkg::OP_PASS;
			end else if (Rnd == 6) begin
				// FL layer after group Grp
				op = cam_pkg::OP_FL;
				gg = chain[c].dec ? (long_key ? 3 - Grp : 2 - Grp) : Grp + 1;
				if (!long_key && chain[c].dec && Grp == 2) op = cam_pkg::OP_PASS;
				if (!long_key && !chain[c].dec && Grp == 2) op = cam_pkg::OP_PASS;
				if (chain[c].dec) begin
					ka = sk.ke[(2*gg - 1) & 7];
					kb = sk.ke[(2*gg - 2) & 7];
				end else begin
					ka = sk.ke[(2*gg - 2) & 7];
					kb = sk.ke[(2*gg - 1) & 7];
				end
			end else begin
				op = cam_pkg::OP_F;
				if (!long_key && Grp == 3) op = cam_pkg::OP_PASS;
				if (chain[c].dec) begin
					ka = long_key ? sk.k[(NR-1-idx) & 31] : sk.k[(17-idx) & 31];
				end else begin
					ka = sk.k[idx & 31];
				end
			end
		end

		cam_pkg::blk_t din;
		always_comb begin
			din = chain[c];
			if (c == 0) begin
				din.a = chain[c].a ^ (chain[c].dec ? sk.kw[2] : sk.kw[0]);
				din.b = chain[c].b ^ (chain[c].dec ? sk.kw[3] : sk.kw[1]);
			end
		end

		cam_cell u_cell (
			.clk, .arst_n, .adv, .op, .key_a(ka), .key_b(kb),
			.din, .dout_q(chain[c+1])
		);
	end

	// Output whitening; F cells swap halves so after an even count a,b are in place
	assign res_out.valid = chain[NC].vld;
	assign res_out.result_high = chain[NC].b ^ (chain[NC].dec ? sk.kw[0] : sk.kw[2]);
	assign res_out.result_low = chain[NC].a ^ (chain[NC].dec ? sk.kw[1] : sk.kw[3]);
endmodule

FILE: rtl/cam_keysched.sv
// Key schedule: four registered F steps build KA, two more KB; subkeys wired out.
module cam_keysched (
	input  logic               clk,
	input  logic [1:0]         key_size_mode,
	input  logic [63:0]        kw0,
	input  logic [63:0]        kw1,
	input  logic [63:0]        kw2,
	input  logic [63:0]        kw3,
	output logic               long_key,
	output cam_pkg::subkeys_t  sk
);
	logic [63:0] kr0, kr1;
	logic [63:0] d1_s1, d2_s1, d1_s2, d2_s2, d1_s3, d2_s3, d1_s4, d2_s4;
	logic [63:0] t1, t2;
	logic [127:0] kl, kr, ka, kb;

	assign long_key = (key_size_mode != 2'd0);
	assign kr0 = long_key ? kw2 : 64'd0;
	assign kr1 = !long_key ? 64'd0 : (key_size_mode == 2'd1) ? ~kw2 : kw3;

	// One F step per stage; key is static while idle so the stages can settle
	assign t1 = (kw1 ^ kr1) ^ cam_pkg::camf(kw0 ^ kr0 ^ cam_pkg::SIG0);
	assign t2 = d2_s1 ^ kw1;
	always_ff @(posedge clk) begin
		d1_s1 <= kw0 ^ kr0;
		d2_s1 <= t1;
		d1_s2 <= (d1_s1 ^ cam_pkg::camf(d2_s1 ^ cam_pkg::SIG1)) ^ kw0;
		d2_s2 <= t2;
		d1_s3 <= d1_s2;
		d2_s3 <= d2_s2 ^ cam_pkg::camf(d1_s2 ^ cam_pkg::SIG2);
		d1_s4 <= d1_s3 ^ cam_pkg::camf(d2_s3 ^ cam_pkg::SIG3);
		d2_s4 <= d2_s3;
	end

	// KB from KA: two more registered F steps
	logic [63:0] e1_s5, e2_s5, e1_s6, e2_s6;
	always_ff @(posedge clk) begin
		e1_s5 <= d1_s4 ^ kr0;
		e2_s5 <= (d2_s4 ^ kr1) ^ cam_pkg::camf(d1_s4 ^ kr0 ^ cam_pkg::SIG4);
		e1_s6 <= e1_s5 ^ cam_pkg::camf(e2_s5 ^ cam_pkg::SIG5);
		e2_s6 <= e2_s5;
	end

	assign kl = {kw0, kw1};
	assign kr = {kr0, kr1};
	assign ka = {d1_s4, d2_s4};
	assign kb = {e1_s6, e2_s6};

	// Subkey placement per key length
	always_comb begin
		logic [127:0] r;
		sk = '0;
		sk.kw[0] = kw0;
		sk.kw[1] = kw1;
		if (!long_key) begin
			r = cam_pkg::rot128(ka, 111); sk.kw[2] = r[127:64]; sk.kw[3] = r[63:0];
			sk.k[0] = ka[127:64]; sk.k[1] = ka[63:0];
			r = cam_pkg::rot128(kl, 15); sk.k[2] = r[127:64]; sk.k[3] = r[63:0];
			r = cam_pkg::rot128(ka, 15); sk.k[4] = r[127:64]; sk.k[5] = r[63:0];
			r = cam_pkg::rot128(ka, 30); sk.ke[0] = r[127:64]; sk.ke[1] = r[63:0];
			r = cam_pkg::rot128(kl, 45); sk.k[6] = r[127:64]; sk.k[7] = r[63:0];
			r = cam_pkg::rot128(ka, 45); sk.k[8] = r[127:64];
			r = cam_pkg::rot128(kl, 60); sk.k[9] = r[63:0];
			r = cam_pkg::rot128(ka, 60); sk.k[10] = r[127:64]; sk.k[11] = r[63:0];
			r = cam_pkg::rot128(kl, 77); sk.ke[2] = r[127:64]; sk.ke[3] = r[63:0];
			r = cam_pkg::rot128(kl, 94); sk.k[12] = r[127:64]; sk.k[13] = r[63:0];
			r = cam_pkg::rot128(ka, 94); sk.k[14] = r[127:64]; sk.k[15] = r[63:0];
			r = cam_pkg::rot128(kl, 111); sk.k[16] = r[127:64]; sk.k[17] = r[63:0];
		end else begin
			r = cam_pkg::rot128(kb, 111); sk.kw[2] = r[127:64]; sk.kw[3] = r[63:0];
			sk.k[0] = kb[127:64]; sk.k[1] = kb[63:0];
			r = cam_pkg::rot128(kr, 15); sk.k[2] = r[127:64]; sk.k[3] = r[63:0];
			r = cam_pkg::rot128(ka, 15); sk.k[4] = r[127:64]; sk.k[5] = r[63:0];
			r = cam_pkg::rot128(kr, 30); sk.ke[0] = r[127:64]; sk.ke[1] = r[63:0];
			r = cam_pkg::rot128(kb, 30); sk.k[6] = r[127:64]; sk.k[7] = r[63:0];
			r = cam_pkg::rot128(kl, 45); sk.k[8] = r[127:64]; sk.k[9] = r[63:0];
			r = cam_pkg::rot128(ka, 45); sk.k[10] = r[127:64]; sk.k[11] = r[63:0];
			r = cam_pkg::rot128(kl, 60); sk.ke[2] = r[127:64]; sk.ke[3] = r[63:0];
			r = cam_pkg::rot128(kr, 60); sk.k[12] = r[127:64]; sk.k[13] = r[63:0];
			r = cam_pkg::rot128(kb, 60); sk.k[14] = r[127:64]; sk.k[15] = r[63:0];
			r = cam_pkg::rot128(kl, 77); sk.k[16] = r[127:64]; sk.k[17] = r[63:0];
			r = cam_pkg::rot128(ka, 77); sk.ke[4] = r[127:64]; sk.ke[5] = r[63:0];
			r = cam_pkg::rot128(kr, 94); sk.k[18] = r[127:64]; sk.k[19] = r[63:0];
			r = cam_pkg::rot128(ka, 94); sk.k[20] = r[127:64]; sk.k[21] = r[63:0];
			r = cam_pkg::rot128(kl, 111); sk.k[22] = r[127:64]; sk.k[23] = r[63:0];
		end
	end
endmodule

FILE: rtl/cam_cell.sv
// One chain cell: F half-round, FL/FL-inverse layer or pass, then a register.
module cam_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  cam_pkg::cell_op_t op,
	input  logic [63:0]       key_a,
	input  logic [63:0]       key_b,
	input  cam_pkg::blk_t     din,
	output cam_pkg::blk_t     dout_q
);
	cam_pkg::blk_t nxt;
	logic        vld_q;
	logic        dec_q;
	logic [63:0] a_q, b_q;

	// F cell swaps halves: new a = b ^ F(a ^ k)
	always_comb begin
		nxt = din;
		case (op)
			cam_pkg::OP_F: begin
				nxt.a = din.b ^ cam_pkg::camf(din.a ^ key_a);
				nxt.b = din.a;
			end
			cam_pkg::OP_FL: begin
				nxt.a = cam_pkg::layer_fl(din.a, key_a);
				nxt.b = cam_pkg::layer_flinv(din.b, key_b);
			end
			default: nxt = din;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dec_q <= nxt.dec;
			a_q <= nxt.a;
			b_q <= nxt.b;
		end
	end

	assign dout_q = {vld_q, dec_q, a_q, b_q};
endmodule

FILE: rtl/cam_checker.sv
// Port-level checker for the Camellia cipher, bound to the top level.
`include "assert_macros.svh"
module cam_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [63:0] out_high
);
	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "result dropped")
	`ASSERT_CLK(a_out_stable, clk, arst_n, out_valid && !out_ready |=> $stable(out_high), "result changed")
	`ASSERT_CLK(a_ready_link, clk, arst_n, !in_ready |-> out_valid && !out_ready, "input stalled without cause")
	`ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> !out_valid, "result during reset")
endmodule

bind camellia_block_cipher cam_checker u_cam_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(blk_in.valid), .in_ready(blk_in.ready),
	.out_valid(res_out.valid), .out_ready(res_out.ready),
	.out_high(res_out.result_high)
);

FILE: tb/tb_camellia_pred.sv
// Behavioral Camellia predictor package: key schedule and block transform.
package tb_camellia_pred;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] KS_C0 = 64'ha09e667f3bcc908b;
	localparam logic [63:0] KS_C1 = 64'hb67ae8584caa73b2;
	localparam logic [63:0] KS_C2 = 64'hc6ef372fe94f82be;
	localparam logic [63:0] KS_C3 = 64'h54ff53a5f1d36f1c;
	localparam logic [63:0] KS_C4 = 64'h10e527fade682d1d;
	localparam logic [63:0] KS_C5 = 64'hb05688c2b3e6c1fd;

	localparam logic [1:0] KSIZE_128 = 2'd0;
	localparam logic [1:0] KSIZE_192 = 2'd1;
	localparam logic [1:0] KSIZE_256 = 2'd2;
	localparam logic [1:0] KSIZE_SPARE = 2'd3;

	localparam byte unsigned SUBST [256] = '{
		112,130, 44,236,179, 39,192,229,228,133, 87, 53,234, 12,174, 65,
		 35,239,107,147, 69, 25,165, 33,237, 14, 79, 78, 29,101,146,189,
		134,184,175,143,124,235, 31,206, 62, 48,220, 95, 94,197, 11, 26,
		166,225, 57,202,213, 71, 93, 61,217,  1, 90,214, 81, 86,108, 77,
		139, 13,154,102,251,204,176, 45,116, 18, 43, 32,240,177,132,153,
		223, 76,203,194, 52,126,118,  5,109,183,169, 49,209, 23,  4,215,
		 20, 88, 58, 97,222, 27, 17, 28, 50, 15,156, 22, 83, 24,242, 34,
		254, 68,207,178,195,181,122,145, 36,  8,232,168, 96,252,105, 80,
		170,208,160,125,161,137, 98,151, 84, 91, 30,149,224,255,100,210,
		 16,196,  0, 72,163,247,117,219,138,  3,230,218,  9, 63,221,148,
		135, 92,131,  2,205, 74,144, 51,115,103,246,243,157,127,191,226,
		 82,155,216, 38,200, 55,198, 59,129,150,111, 75, 19,190, 99, 46,
		233,121,167,140,159,110,188,142, 41,245,249,182, 47,253,180, 89,
		120,152,  6,106,231, 70,113,186,212, 37,171, 66,136,162,141,250,
		114,  7,185, 85,248,238,172, 10, 54, 73, 42,104, 60, 56,241,164,
		 64, 40,211,123,187,201, 67,193, 21,227,173,244,119,199,128,158
	};

	function automatic logic [7:0] bl(input logic [7:0] v);
		return {v[6:0], v[7]};
	endfunction

	function automatic logic [7:0] br(input logic [7:0] v);
		return {v[0], v[7:1]};
	endfunction

	// S layer then byte diffusion
	function automatic logic [63:0] round_mix(input logic [63:0] x);
		logic [7:0] t [1:8];
		logic [7:0] y [1:8];
		t[1] = SUBST[x[63:56]];
		t[2] = bl(SUBST[x[55:48]]);
		t[3] = br(SUBST[x[47:40]]);
		t[4] = SUBST[bl(x[39:32])];
		t[5] = bl(SUBST[x[31:24]]);
		t[6] = br(SUBST[x[23:16]]);
		t[7] = SUBST[bl(x[15:8])];
		t[8] = SUBST[x[7:0]];
		y[1] = t[1] ^ t[3] ^ t[4] ^ t[6] ^ t[7] ^ t[8];
		y[2] = t[1] ^ t[2] ^ t[4] ^ t[5] ^ t[7] ^ t[8];
		y[3] = t[1] ^ t[2] ^ t[3] ^ t[5] ^ t[6] ^ t[8];
		y[4] = t[2] ^ t[3] ^ t[4] ^ t[5] ^ t[6] ^ t[7];
		y[5] = t[1] ^ t[2] ^ t[6] ^ t[7] ^ t[8];
		y[6] = t[2] ^ t[3] ^ t[5] ^ t[7] ^ t[8];
		y[7] = t[3] ^ t[4] ^ t[5] ^ t[6] ^ t[8];
		y[8] = t[1] ^ t[4] ^ t[5] ^ t[6] ^ t[7];
		return {y[1], y[2], y[3], y[4], y[5], y[6], y[7], y[8]};
	endfunction

	function automatic logic [63:0] fl_fwd(input logic [63:0] x, input logic [63:0] k);
		logic [31:0] l, r, m;
		l = x[63:32];
		r = x[31:0];
		m = l & k[63:32];
		r ^= {m[30:0], m[31]};
		l ^= r | k[31:0];
		return {l, r};
	endfunction

	function automatic logic [63:0] fl_back(input logic [63:0] x, input logic [63:0] k);
		logic [31:0] l, r, m;
		l = x[63:32];
		r = x[31:0];
		l ^= r | k[31:0];
		m = l & k[63:32];
		r ^= {m[30:0], m[31]};
		return {l, r};
	endfunction

	function automatic logic [127:0] rotl128(input logic [127:0] v, input int n);
		return (v << n) | (v >> (128 - n));
	endfunction

	typedef struct {
		logic [63:0] w [4];
		logic [63:0] fk [6];
		logic [63:0] rk [24];
	} sched_t;

	// Subkey schedule from the configured key
	function automatic sched_t make_schedule(input logic [1:0] ksize,
			input logic [63:0] kw0, kw1, kw2, kw3);
		sched_t s;
		logic [127:0] kl, kr, ka, kb, t;
		logic [63:0] d1, d2;
		bit wide;
		wide = ksize != KSIZE_128;
		kl = {kw0, kw1};
		kr = '0;
		if (wide) kr = {kw2, (ksize == KSIZE_192) ? ~kw2 : kw3};
		d1 = kl[127:64] ^ kr[127:64];
		d2 = kl[63:0] ^ kr[63:0];
		d2 ^= round_mix(d1 ^ KS_C0);
		d1 ^= round_mix(d2 ^ KS_C1);
		d1 ^= kl[127:64];
		d2 ^= kl[63:0];
		d2 ^= round_mix(d1 ^ KS_C2);
		d1 ^= round_mix(d2 ^ KS_C3);
		ka = {d1, d2};
		s.w[0] = kl[127:64];
		s.w[1] = kl[63:0];
		for (int i = 0; i < 6; i++) s.fk[i] = '0;
		for (int i = 0; i < 24; i++) s.rk[i] = '0;
		if (!wide) begin
			{s.w[2], s.w[3]} = rotl128(ka, 111);
			{s.rk[0], s.rk[1]} = ka;
			{s.rk[2], s.rk[3]} = rotl128(kl, 15);
			{s.rk[4], s.rk[5]} = rotl128(ka, 15);
			{s.fk[0], s.fk[1]} = rotl128(ka, 30);
			{s.rk[6], s.rk[7]} = rotl128(kl, 45);
			t = rotl128(ka, 45);
			s.rk[8] = t[127:64];
			t = rotl128(kl, 60);
			s.rk[9] = t[63:0];
			{s.rk[10], s.rk[11]} = rotl128(ka, 60);
			{s.fk[2], s.fk[3]} = rotl128(kl, 77);
			{s.rk[12], s.rk[13]} = rotl128(kl, 94);
			{s.rk[14], s.rk[15]} = rotl128(ka, 94);
			{s.rk[16], s.rk[17]} = rotl128(kl, 111);
		end else begin
			d1 ^= kr[127:64];
			d2 ^= kr[63:0];
			d2 ^= round_mix(d1 ^ KS_C4);
			d1 ^= round_mix(d2 ^ KS_C5);
			kb = {d1, d2};
			{s.w[2], s.w[3]} = rotl128(kb, 111);
			{s.rk[0], s.rk[1]} = kb;
			{s.rk[2], s.rk[3]} = rotl128(kr, 15);
			{s.rk[4], s.rk[5]} = rotl128(ka, 15);
			{s.fk[0], s.fk[1]} = rotl128(kr, 30);
			{s.rk[6], s.rk[7]} = rotl128(kb, 30);
			{s.rk[8], s.rk[9]} = rotl128(kl, 45);
			{s.rk[10], s.rk[11]} = rotl128(ka, 45);
			{s.fk[2], s.fk[3]} = rotl128(kl, 60);
			{s.rk[12], s.rk[13]} = rotl128(kr, 60);
			{s.rk[14], s.rk[15]} = rotl128(kb, 60);
			{s.rk[16], s.rk[17]} = rotl128(kl, 77);
			{s.fk[4], s.fk[5]} = rotl128(ka, 77);
			{s.rk[18], s.rk[19]} = rotl128(kr, 94);
			{s.rk[20], s.rk[21]} = rotl128(ka, 94);
			{s.rk[22], s.rk[23]} = rotl128(kl, 111);
		end
		return s;
	endfunction

	// One block through the cipher; returns {high, low}
	function automatic logic [127:0] cipher_block(input sched_t s, input bit wide,
			input logic decrypt, input logic [63:0] hi, lo);
		logic [63:0] a, b;
		int groups;
		groups = wide ? 4 : 3;
		if (!decrypt) begin
			a = hi ^ s.w[0];
			b = lo ^ s.w[1];
			for (int g = 0; g < groups; g++) begin
				if (g > 0) begin
					a = fl_fwd(a, s.fk[2*g-2]);
					b = fl_back(b, s.fk[2*g-1]);
				end
				for (int r = 0; r < 3; r++) begin
					b ^= round_mix(a ^ s.rk[6*g+2*r]);
					a ^= round_mix(b ^ s.rk[6*g+2*r+1]);
				end
			end
			return {b ^ s.w[2], a ^ s.w[3]};
		end
		a = hi ^ s.w[2];
		b = lo ^ s.w[3];
		for (int g = groups - 1; g >= 0; g--) begin
			for (int r = 0; r < 3; r++) begin
				b ^= round_mix(a ^ s.rk[6*g+5-2*r]);
				a ^= round_mix(b ^ s.rk[6*g+4-2*r]);
			end
			if (g > 0) begin
				a = fl_fwd(a, s.fk[2*g-1]);
				b = fl_back(b, s.fk[2*g-2]);
			end
		end
		return {b ^ s.w[0], a ^ s.w[1]};
	endfunction
endpackage

FILE: tb/tb.sv
// Testbench top: drives blocks and key settings, checks results against a predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;
	localparam int KEY_SETTLE = 8;
	localparam int HOLD_CYCLES = 150;

	typedef struct {
		logic        kind;
		logic [63:0] hi;
		logic [63:0] lo;
	} blk_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	cam_blk_if blk ();
	cam_res_if res ();
	cam_cfg_if cfg ();

	camellia_block_cipher i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.blk_in(blk.sink),
		.res_out(res.source),
		.cfg(cfg.sink)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor copy of the key registers
	logic [1:0]  key_size;
	logic [63:0] key_w [4];
	tb_camellia_pred::sched_t sched;

	blk_beat_t   pending_blocks [$];
	logic [127:0] expected_blocks [$];
	int          error_count = 0;
	int          cycle_count = 0;
	bit          hold_req = 1'b0;
	bit          hold_off = 1'b0;
	int          hold_count = 0;
	int          gap_left = 0;
	int          burst_left = 0;

	task automatic report_mismatch(input string what, input logic [63:0] got, exp_v);
		$display("tb: mismatch %s got %h expected %h at %0t", what, got, exp_v, $realtime);
		error_count++;
	endtask

	// Block driver: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk.valid <= 1'b0;
			blk.kind <= 1'b0;
			blk.data_high <= '0;
			blk.data_low <= '0;
		end else begin
			if (blk.valid && blk.ready) begin
				automatic blk_beat_t b = pending_blocks.pop_front();
				expected_blocks.push_back(tb_camellia_pred::cipher_block(sched,
					key_size != tb_camellia_pred::KSIZE_128, b.kind, b.hi, b.lo));
			end
			if (!blk.valid || blk.ready) begin
				if (gap_left > 0) begin
					blk.valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_blocks.size() > 0) begin
					blk.valid <= 1'b1;
					blk.kind <= pending_blocks[0].kind;
					blk.data_high <= pending_blocks[0].hi;
					blk.data_low <= pending_blocks[0].lo;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(0, 20);
						gap_left <= $urandom_range(0, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					blk.valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted here once the stimulus arms it
	always @(posedge clk) begin
		if (!hold_req) begin
			hold_off <= 1'b0;
			hold_count <= 0;
		end else if (hold_count < HOLD_CYCLES) begin
			hold_off <= 1'b1;
			hold_count <= hold_count + 1;
		end else begin
			hold_off <= 1'b0;
		end
	end

	// Result monitor and receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (res.valid && res.ready) begin
				if (expected_blocks.size() == 0) begin
					report_mismatch("unexpected beat", res.result_high, '0);
				end else begin
					automatic logic [127:0] e = expected_blocks.pop_front();
					if (res.result_high !== e[127:64])
						report_mismatch("result_high", res.result_high, e[127:64]);
					if (res.result_low !== e[63:0])
						report_mismatch("result_low", res.result_low, e[63:0]);
				end
			end
			if (hold_off) res.ready <= 1'b0;
			else if (cycle_count[9:8] == 2'd3) res.ready <= 1'b1;
			else res.ready <= $urandom_range(0, 3) != 0;
		end
	end

	always @(posedge clk) begin
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// One register write, then time for the key schedule to settle
	task automatic write_reg(input cam_pkg::cfg_reg_t idx, input logic [63:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		case (idx)
			cam_pkg::REG_KEY_SIZE: key_size = value[1:0];
			cam_pkg::REG_KEY_W0: key_w[0] = value;
			cam_pkg::REG_KEY_W1: key_w[1] = value;
			cam_pkg::REG_KEY_W2: key_w[2] = value;
			cam_pkg::REG_KEY_W3: key_w[3] = value;
			default: ;
		endcase
		sched = tb_camellia_pred::make_schedule(key_size, key_w[0], key_w[1], key_w[2],
			key_w[3]);
		repeat (KEY_SETTLE) @(posedge clk);
	endtask

	task automatic wait_idle();
		while (pending_blocks.size() > 0 || blk.valid || expected_blocks.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic add_block(input logic kind, input logic [63:0] hi, lo);
		blk_beat_t b;
		b.kind = kind;
		b.hi = hi;
		b.lo = lo;
		pending_blocks.push_back(b);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic random_phase(input int count);
		for (int i = 0; i < count; i++)
			add_block(1'($urandom_range(0, 1)), rand64(), rand64());
	endtask

	initial begin
		cfg.valid = 1'b0;
		cfg.index = cam_pkg::REG_KEY_SIZE;
		cfg.data = '0;
		key_size = tb_camellia_pred::KSIZE_128;
		for (int i = 0; i < 4; i++) key_w[i] = '0;
		sched = tb_camellia_pred::make_schedule(key_size, key_w[0], key_w[1], key_w[2],
			key_w[3]);
		#1 arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset key, extremes and both directions; includes the standard test vector
		add_block(1'b0, '0, '0);
		add_block(1'b1, '0, '0);
		add_block(1'b0, '1, '1);
		add_block(1'b1, '1, '1);
		wait_idle();
		write_reg(cam_pkg::REG_KEY_W0, 64'h0123456789abcdef);
		write_reg(cam_pkg::REG_KEY_W1, 64'hfedcba9876543210);
		add_block(1'b0, 64'h0123456789abcdef, 64'hfedcba9876543210);
		add_block(1'b1, 64'h6767313854966973, 64'h0857065648eabe43);
		add_block(1'b0, 64'h8000000000000000, 64'h0000000000000001);
		wait_idle();

		// Each key size, the spare size code and extreme key words
		for (int m = 0; m < 4; m++) begin
			write_reg(cam_pkg::REG_KEY_SIZE, 64'(m));
			write_reg(cam_pkg::REG_KEY_W2, (m == 2) ? '1 : 64'h0011223344556677);
			write_reg(cam_pkg::REG_KEY_W3, (m == 3) ? '0 : 64'h8899aabbccddeeff);
			add_block(1'b0, 64'h0123456789abcdef, 64'hfedcba9876543210);
			add_block(1'b1, 64'h0123456789abcdef, 64'hfedcba9876543210);
			add_block(1'b0, '1, '0);
			add_block(1'b1, '0, '1);
			wait_idle();
		end
		// Out-of-range register index must be ignored
		cfg.valid <= 1'b1;
		cfg.index <= 3'd7;
		cfg.data <= '1;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		add_block(1'b0, 64'h1, 64'h2);
		wait_idle();

		// Long receiver hold-off while blocks keep coming
		hold_req = 1'b1;
		random_phase(80);
		wait_idle();
		hold_req = 1'b0;

		// Random key settings, each followed by random blocks
		for (int p = 0; p < 12; p++) begin
			write_reg(cam_pkg::REG_KEY_SIZE, (p < 3) ? 64'(p) : 64'($urandom_range(0, 3)));
			write_reg(cam_pkg::REG_KEY_W0, (p == 4) ? '1 : rand64());
			write_reg(cam_pkg::REG_KEY_W1, (p == 4) ? '1 : rand64());
			write_reg(cam_pkg::REG_KEY_W2, (p == 5) ? '0 : rand64());
			write_reg(cam_pkg::REG_KEY_W3, (p == 5) ? '1 : rand64());
			random_phase(125);
			wait_idle();
		end

		if (error_count == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end
endmodule
